// File: rtl/core/frd_pkg.sv
// shared types and codes for the fastcgi record deframer
package frd_pkg;

  // request action codes
  localparam logic [1:0] ACT_DATA    = 2'd0;
  localparam logic [1:0] ACT_CONNECT = 2'd1;
  localparam logic [1:0] ACT_CLOSE   = 2'd2;
  // unused action code, ignored by the block
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  // result kind codes
  localparam logic [2:0] KIND_BYTE     = 3'd0;
  localparam logic [2:0] KIND_COMPLETE = 3'd1;
  localparam logic [2:0] KIND_END_REQ  = 3'd2;
  localparam logic [2:0] KIND_PROTO    = 3'd3;
  localparam logic [2:0] KIND_CLOSED   = 3'd4;

  // record types of interest
  localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
  localparam logic [7:0] TYPE_STDOUT      = 8'd6;

  // minimum content length of an end-request record
  localparam logic [15:0] END_BODY_MIN = 16'd8;

  // header byte positions
  localparam logic [2:0] HDR_TYPE   = 3'd1;
  localparam logic [2:0] HDR_ID_HI  = 3'd2;
  localparam logic [2:0] HDR_ID_LO  = 3'd3;
  localparam logic [2:0] HDR_LEN_HI = 3'd4;
  localparam logic [2:0] HDR_LEN_LO = 3'd5;
  localparam logic [2:0] HDR_PAD    = 3'd6;
  localparam logic [2:0] HDR_LAST   = 3'd7;

  // one result between parser and output stage
  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [15:0] request_id;
    logic [7:0]  out_byte;
  } frd_result_t;

endpackage

// File: rtl/core/frd_if.sv
// valid/ready channel interfaces for the deframer input and result streams
interface frd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface frd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] request_id;
  logic [7:0]  out_byte;

  modport source (output valid, output kind, output request_id, output out_byte,
                  input ready);
  modport sink   (input valid, input kind, input request_id, input out_byte,
                  output ready);
endinterface

// File: rtl/core/frd_parser.sv
// record parser state and per-byte step logic
module frd_parser
  import frd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  output frd_result_t res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  header_count_r, header_count_nxt;
  logic [7:0]  record_type_r, record_type_nxt;
  logic [15:0] record_id_r, record_id_nxt;
  logic [15:0] content_length_r, content_length_nxt;
  logic [7:0]  padding_length_r, padding_length_nxt;
  logic [16:0] body_count_r, body_count_nxt;

  logic [16:0] body_total;
  logic [17:0] body_pos_inc;
  logic        is_content;
  logic        is_last;

  // body position bookkeeping
  assign body_total   = {1'b0, content_length_r} + {9'd0, padding_length_r};
  assign body_pos_inc = {1'b0, body_count_r} + 18'd1;
  assign is_content   = body_count_r < {1'b0, content_length_r};
  assign is_last      = body_pos_inc >= {1'b0, body_total};

  // next state and result for one request
  always_comb begin
    phase_nxt          = phase_r;
    header_count_nxt   = header_count_r;
    record_type_nxt    = record_type_r;
    record_id_nxt      = record_id_r;
    content_length_nxt = content_length_r;
    padding_length_nxt = padding_length_r;
    body_count_nxt     = body_count_r;
    res                = '0;
    if (step_en) begin
      case (action)
        ACT_CONNECT: begin
          phase_nxt          = PH_HEADER;
          header_count_nxt   = '0;
          record_type_nxt    = '0;
          record_id_nxt      = '0;
          content_length_nxt = '0;
          padding_length_nxt = '0;
          body_count_nxt     = '0;
        end
        ACT_CLOSE: begin
          if (phase_r == PH_HEADER || phase_r == PH_BODY) begin
            phase_nxt  = PH_HALT;
            res.valid  = 1'b1;
            res.kind   = KIND_CLOSED;
          end
        end
        ACT_DATA: begin
          unique case (phase_r)
            PH_HEADER: begin
              // capture header fields
              case (header_count_r)
                HDR_TYPE:   record_type_nxt = data_byte;
                HDR_ID_HI:  record_id_nxt = {data_byte, record_id_r[7:0]};
                HDR_ID_LO:  record_id_nxt = {record_id_r[15:8], data_byte};
                HDR_LEN_HI: content_length_nxt = {data_byte, content_length_r[7:0]};
                HDR_LEN_LO: content_length_nxt = {content_length_r[15:8], data_byte};
                HDR_PAD:    padding_length_nxt = data_byte;
                default:    ;
              endcase
              if (header_count_r != HDR_LAST) begin
                header_count_nxt = header_count_r + 3'd1;
              end else begin
                header_count_nxt = '0;
                body_count_nxt   = '0;
                if (record_type_r == TYPE_END_REQUEST &&
                    content_length_r < END_BODY_MIN) begin
                  phase_nxt = PH_HALT;
                  res.valid = 1'b1;
                  res.kind  = KIND_PROTO;
                end else if (content_length_r == '0 && padding_length_r == '0) begin
                  phase_nxt = PH_HEADER;
                end else begin
                  phase_nxt = PH_BODY;
                end
              end
            end
            PH_BODY: begin
              body_count_nxt = body_pos_inc[16:0];
              if (is_last) begin
                phase_nxt        = PH_HEADER;
                header_count_nxt = '0;
                body_count_nxt   = '0;
                if (record_type_r == TYPE_STDOUT && content_length_r != '0) begin
                  res.valid      = 1'b1;
                  res.kind       = KIND_COMPLETE;
                  res.request_id = record_id_r;
                  res.out_byte   = is_content ? data_byte : 8'd0;
                end else if (record_type_r == TYPE_END_REQUEST) begin
                  res.valid      = 1'b1;
                  res.kind       = KIND_END_REQ;
                  res.request_id = record_id_r;
                end
              end else if (is_content && record_type_r == TYPE_STDOUT) begin
                res.valid      = 1'b1;
                res.kind       = KIND_BYTE;
                res.request_id = record_id_r;
                res.out_byte   = data_byte;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HEADER;
      header_count_r   <= '0;
      record_type_r    <= '0;
      record_id_r      <= '0;
      content_length_r <= '0;
      padding_length_r <= '0;
      body_count_r     <= '0;
    end else begin
      phase_r          <= phase_nxt;
      header_count_r   <= header_count_nxt;
      record_type_r    <= record_type_nxt;
      record_id_r      <= record_id_nxt;
      content_length_r <= content_length_nxt;
      padding_length_r <= padding_length_nxt;
      body_count_r     <= body_count_nxt;
    end
  end

endmodule

// File: rtl/core/frd_out_stage.sv
// result register between parser and output channel
module frd_out_stage
  import frd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  frd_result_t res,
  input  logic        out_ready,
  output logic        space,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [15:0] out_request_id,
  output logic [7:0]  out_byte
);

  logic        valid_r, valid_nxt;
  logic [2:0]  kind_r;
  logic [15:0] request_id_r;
  logic [7:0]  byte_r;

  // free when empty or draining this cycle
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res.valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload loads with every accepted request
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r       <= res.kind;
      request_id_r <= res.request_id;
      byte_r       <= res.out_byte;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_request_id = request_id_r;
  assign out_byte       = byte_r;

endmodule

// File: rtl/core/fastcgi_record_deframer_unit.sv
// top level of the fastcgi reply record deframer
//
// in_chan takes one request per cycle while in_chan.ready is high:
// action (data byte, connect, close) and data_byte. The parser collects
// each 8-byte record header, then walks the content and padding. STDOUT
// content bytes go out on out_chan tagged with the request id; the last
// body byte gives a record-complete result instead, carrying that byte
// if it is content. An END_REQUEST record gives an end-of-request result.
// A short END_REQUEST or a close halts the parser until a connect request.
// A result appears on out_chan in the cycle after its request is accepted.
// Throughput: one request per cycle, set by the single result register.
// The result register is refilled in the cycle it drains, so in_chan.ready
// stays high while out_chan.ready is high. When the receiver stalls with a
// result held, in_chan.ready drops until it is taken.
// Reset (rst_n low, synchronous) clears the parser to await a header and
// empties the result register.
module fastcgi_record_deframer_unit
  import frd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  frd_in_if.sink    in_chan,
  frd_out_if.source out_chan
);

  frd_result_t step_res;
  logic        stage_space;
  logic        in_accept;

  assign in_chan.ready = stage_space;
  assign in_accept     = in_chan.valid && stage_space;

  // record parser
  frd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_accept),
    .action    (in_chan.action),
    .data_byte (in_chan.data_byte),
    .res       (step_res)
  );

  // result register
  frd_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_accept),
    .res            (step_res),
    .out_ready      (out_chan.ready),
    .space          (stage_space),
    .out_valid      (out_chan.valid),
    .out_kind       (out_chan.kind),
    .out_request_id (out_chan.request_id),
    .out_byte       (out_chan.out_byte)
  );

endmodule

// File: rtl/core/frd_checker.sv
// port-level checks for the deframer, bound to the top level
module frd_checker
  import frd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [15:0] out_request_id,
  input logic [7:0]  out_byte
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_request_id) && $stable(out_byte))
    else $error("result changed while stalled");

  // connect and unused actions never produce a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_CONNECT || in_action == ACT_UNUSED)
    |=> !out_valid)
    else $error("result from a request that gives none");

  // halt kinds carry no id and no byte
  a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PROTO || out_kind == KIND_CLOSED)
    |-> out_request_id == 16'd0 && out_byte == 8'd0)
    else $error("halt result with payload");

  // input is taken whenever the result side drains
  a_ready_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled with room in result register");

endmodule

bind fastcgi_record_deframer_unit frd_checker u_frd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_action      (in_chan.action),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_kind       (out_chan.kind),
  .out_request_id (out_chan.request_id),
  .out_byte       (out_chan.out_byte)
);

// File: tb/tb_top.sv
// self-checking testbench for the fastcgi record deframer unit
module tb_top
  import frd_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {AWAIT_HEADER, AWAIT_BODY, HALTED} parse_phase_t;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] request_id;
    logic [7:0]  out_byte;
  } frd_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  frd_in_if  in_if();
  frd_out_if out_if();

  fastcgi_record_deframer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // replies predicted but not yet seen on the result channel
  frd_reply_t pending_replies[$];

  // shadow parser state
  parse_phase_t parse_phase;
  logic [2:0]   hdr_pos;
  logic [7:0]   rec_type;
  logic [15:0]  rec_id;
  logic [15:0]  rec_len;
  logic [7:0]   rec_pad;
  logic [16:0]  body_pos;

  int live_requests;
  int mismatch_count;
  int cycle_count;
  int sender_idle_pct;
  int receiver_stall_pct;

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic void note_reply(input logic [2:0] kind, input logic [15:0] id,
                                     input logic [7:0] b);
    frd_reply_t r;
    r.kind       = kind;
    r.request_id = id;
    r.out_byte   = b;
    pending_replies.push_back(r);
  endfunction

  function automatic void clear_parser();
    parse_phase = AWAIT_HEADER;
    hdr_pos     = '0;
    rec_type    = '0;
    rec_id      = '0;
    rec_len     = '0;
    rec_pad     = '0;
    body_pos    = '0;
  endfunction

  // shadow deframer: one accepted request in, at most one predicted reply out
  function automatic void predict_request(input logic [1:0] act, input logic [7:0] b);
    logic [16:0] total;
    logic [16:0] pos;
    logic        is_content;
    logic        last;
    if (act == ACT_CONNECT) begin
      clear_parser();
      live_requests++;
    end else if (act == ACT_CLOSE) begin
      if (parse_phase != HALTED) begin
        parse_phase = HALTED;
        note_reply(KIND_CLOSED, 16'd0, 8'd0);
        live_requests++;
      end
    end else if (act == ACT_DATA && parse_phase == AWAIT_HEADER) begin
      live_requests++;
      case (hdr_pos)
        HDR_TYPE:   rec_type = b;
        HDR_ID_HI:  rec_id[15:8] = b;
        HDR_ID_LO:  rec_id[7:0] = b;
        HDR_LEN_HI: rec_len[15:8] = b;
        HDR_LEN_LO: rec_len[7:0] = b;
        HDR_PAD:    rec_pad = b;
        default: ;
      endcase
      if (hdr_pos != HDR_LAST) begin
        hdr_pos = hdr_pos + 3'd1;
      end else begin
        hdr_pos  = '0;
        body_pos = '0;
        // short end-request halts, empty body goes straight to the next header
        if (rec_type == TYPE_END_REQUEST && rec_len < END_BODY_MIN) begin
          parse_phase = HALTED;
          note_reply(KIND_PROTO, 16'd0, 8'd0);
        end else if (rec_len != 16'd0 || rec_pad != 8'd0) begin
          parse_phase = AWAIT_BODY;
        end
      end
    end else if (act == ACT_DATA && parse_phase == AWAIT_BODY) begin
      live_requests++;
      pos        = body_pos;
      total      = {1'b0, rec_len} + {9'd0, rec_pad};
      is_content = pos < {1'b0, rec_len};
      last       = (pos + 17'd1) >= total;
      body_pos   = pos + 17'd1;
      if (last) begin
        parse_phase = AWAIT_HEADER;
        hdr_pos     = '0;
        body_pos    = '0;
        if (rec_type == TYPE_STDOUT && rec_len != 16'd0)
          note_reply(KIND_COMPLETE, rec_id, is_content ? b : 8'd0);
        else if (rec_type == TYPE_END_REQUEST)
          note_reply(KIND_END_REQ, rec_id, 8'd0);
      end else if (is_content && rec_type == TYPE_STDOUT) begin
        note_reply(KIND_BYTE, rec_id, b);
      end
    end
  endfunction

  // drive one request and wait for it to be taken
  task automatic send_request(input logic [1:0] act, input logic [7:0] b);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.data_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_request(act, b);
    @(negedge clk);
  endtask

  // header plus up to body_limit random body bytes
  task automatic send_record(input logic [7:0] rtype, input logic [15:0] rid,
                             input logic [15:0] clen, input logic [7:0] pad,
                             input int body_limit);
    send_request(ACT_DATA, 8'($urandom));
    send_request(ACT_DATA, rtype);
    send_request(ACT_DATA, rid[15:8]);
    send_request(ACT_DATA, rid[7:0]);
    send_request(ACT_DATA, clen[15:8]);
    send_request(ACT_DATA, clen[7:0]);
    send_request(ACT_DATA, pad);
    send_request(ACT_DATA, 8'($urandom));
    for (int i = 0; i < int'(clen) + int'(pad) && i < body_limit; i++)
      send_request(ACT_DATA, 8'($urandom));
  endtask

  task automatic end_phase();
    in_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver side: random stalls
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin
    frd_reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %h byte %h",
                                  out_if.kind, out_if.request_id, out_if.out_byte));
      end else begin
        want = pending_replies.pop_front();
        if (out_if.kind !== want.kind || out_if.request_id !== want.request_id ||
            out_if.out_byte !== want.out_byte)
          report_mismatch($sformatf("got kind %0d id %h byte %h, wanted kind %0d id %h byte %h",
                                    out_if.kind, out_if.request_id, out_if.out_byte,
                                    want.kind, want.request_id, want.out_byte));
      end
    end
  end

  // stdout framing: padded record, unpadded last byte, zero content with padding, empty body
  task automatic test_stdout_framing();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_request(ACT_CONNECT, 8'hFF);
    send_record(TYPE_STDOUT, 16'hFFFF, 16'd1, 8'd1, 0);
    send_request(ACT_DATA, 8'h00);
    send_request(ACT_DATA, 8'hFF);
    send_record(TYPE_STDOUT, 16'h0000, 16'd1, 8'd0, 0);
    send_request(ACT_DATA, 8'hFF);
    send_record(TYPE_STDOUT, 16'h5AA5, 16'd0, 8'd1, 1);
    send_record(TYPE_STDOUT, 16'hA55A, 16'd0, 8'd0, 0);
    end_phase();
  endtask

  // halts: short end-request, data and close while halted, unused action, cut short
  task automatic test_halt_paths();
    send_record(TYPE_END_REQUEST, 16'h1234, 16'd7, 8'd0, 0);
    send_request(ACT_DATA, 8'hA5);
    send_request(ACT_CLOSE, 8'h00);
    send_request(ACT_UNUSED, 8'hFF);
    send_request(ACT_CONNECT, 8'h00);
    send_request(ACT_UNUSED, 8'h00);
    send_record(TYPE_STDOUT, 16'hFFFF, 16'hFFFF, 8'hFF, 1);
    send_request(ACT_CLOSE, 8'hFF);
    send_request(ACT_CLOSE, 8'h00);
    send_request(ACT_CONNECT, 8'h00);
    end_phase();
  endtask

  // mostly well-formed records with random content, plus broken and noisy sequences
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int goal;
    int pick;
    int r;
    logic [7:0]  rtype;
    logic [15:0] clen;
    logic [7:0]  pad;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    goal = live_requests + n_items;
    while (live_requests < goal) begin
      if (parse_phase == HALTED)
        send_request(ACT_CONNECT, 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 70) begin
        r = $urandom_range(99);
        if (r < 50) begin
          rtype = TYPE_STDOUT;
          r = $urandom_range(99);
          if (r < 80) clen = 16'($urandom_range(6));
          else if (r < 96) clen = 16'($urandom_range(40, 7));
          else clen = 16'($urandom_range(300, 100));
        end else if (r < 70) begin
          rtype = TYPE_END_REQUEST;
          clen  = ($urandom_range(99) < 15) ? 16'($urandom_range(7)) :
                                              16'($urandom_range(12, 8));
        end else begin
          rtype = 8'($urandom);
          clen  = 16'($urandom_range(6));
        end
        r = $urandom_range(99);
        if (r < 60) pad = 8'd0;
        else if (r < 97) pad = 8'($urandom_range(4, 1));
        else pad = 8'($urandom_range(255, 200));
        send_record(rtype, 16'($urandom), clen, pad, 1 << 20);
      end else if (pick < 80) begin
        // random header, a few body bytes, then close
        send_record(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                    $urandom_range(6));
        send_request(ACT_CLOSE, 8'($urandom));
      end else if (pick < 88) begin
        // noise burst, then reconnect
        repeat ($urandom_range(4, 1)) send_request(2'($urandom), 8'($urandom));
        send_request(ACT_CONNECT, 8'($urandom));
      end else if (pick < 94) begin
        // header broken off by a reconnect
        repeat ($urandom_range(7, 1)) send_request(ACT_DATA, 8'($urandom));
        send_request(ACT_CONNECT, 8'($urandom));
      end else begin
        // close, then traffic into the halted parser
        send_request(ACT_CLOSE, 8'($urandom));
        repeat ($urandom_range(2)) send_request(ACT_DATA, 8'($urandom));
        if ($urandom_range(1) == 1) send_request(ACT_CLOSE, 8'($urandom));
      end
    end
    end_phase();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_DATA;
    in_if.data_byte    = 8'd0;
    out_if.ready       = 1'b0;
    live_requests      = 0;
    mismatch_count     = 0;
    cycle_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_stdout_framing();
    test_halt_paths();
    test_random_traffic(0, 0, 330);
    test_random_traffic(71, 0, 330);
    test_random_traffic(0, 71, 330);
    test_random_traffic(11, 11, 330);

    // drain, then keep watching the quiet result channel for anything unpredicted
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
